// ===== sv/command_frame_builder_sum16_defines.svh =====
// Assertion macros shared by the frame builder RTL.
`ifndef COMMAND_FRAME_BUILDER_SUM16_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_SUM16_DEFINES_SVH

`ifndef SYNTH

// Check that a condition implies a consequence in the same cycle.
`define CFB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Check that a condition implies a consequence in the next cycle.
`define CFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`else

`define CFB_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define CFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/cfb_pkg.sv =====
// Types and constants of the command frame builder.
package cfb_pkg;

    localparam int unsigned MAX_PAYLOAD_WORDS = 128;

    localparam logic [7:0]  MAX_COUNT  = 8'(MAX_PAYLOAD_WORDS);
    localparam logic [15:0] SYNC_WORD  = 16'hFF55;
    localparam logic [15:0] HEAD_WORDS = 16'd4;

    // Item kinds
    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Word slot inside the words that one item produces
    typedef logic [2:0] t_slot;
    localparam t_slot SLOT_SYNC     = 3'd0;
    localparam t_slot SLOT_LEN      = 3'd1;
    localparam t_slot SLOT_ID       = 3'd2;
    localparam t_slot SLOT_CH       = 3'd3;
    localparam t_slot SLOT_NO       = 3'd4;
    localparam t_slot SLOT_HDR_SUM  = 3'd5;
    localparam t_slot SLOT_PAY_WORD = 3'd0;
    localparam t_slot SLOT_PAY_SUM  = 3'd1;

    typedef struct packed {
        logic        command;
        logic [15:0] cmd_id;
        logic [15:0] channel;
        logic [15:0] sub_number;
        logic [7:0]  word_count;
        logic [15:0] payload_word;
    } t_cmd_item;

    typedef struct packed {
        logic [15:0] frame_word;
        logic        frame_end;
    } t_frame_item;

endpackage

// ===== sv/cfb_if.sv =====
// Valid/ready channel interfaces of the command frame builder.
interface cfb_cmd_if import cfb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmd_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cfb_frame_if import cfb_pkg::*; ();
    logic        valid;
    logic        ready;
    t_frame_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/command_frame_builder_sum16.sv =====
// Command frame builder: expands header and payload beats into 16-bit frame words.
`include "command_frame_builder_sum16_defines.svh"

// Command frame builder with 16-bit additive checksum.
// A header beat (command = 0) opens a frame and produces the words 0xFF55,
// length (payload words + 4, word_count saturated at MAX_PAYLOAD_WORDS), id,
// channel and sub-number. Each payload beat (command = 1) passes its word
// through; the beat that brings the last expected word also produces the
// checksum word (wrapping sum of every word after the sync word), flagged by
// frame_end. A header with word_count 0 closes its frame at once with the
// checksum. A payload beat with no frame open is dropped. A header arriving
// mid-frame abandons the open frame without a checksum.
// Timing: an accepted beat lands in an input register; from there one frame
// word per cycle, while the output is ready, is built by short logic and
// written into the output word register, which frees the input register as
// soon as the item's last word moves out. A payload beat yields one word (two
// when it closes the frame), a header five (six for an empty payload), a
// dropped beat none. Payload beats thus stream at one per cycle with no
// bubbles while the output is ready. Ready on the input depends
// combinationally on ready at the output.
module command_frame_builder_sum16
    import cfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    cfb_cmd_if.sink            i_cmd,
    cfb_frame_if.source        o_frame
);

    // Input register
    logic        r_in_valid;
    t_cmd_item   r_cmd;
    t_slot       r_idx;

    // Frame state
    logic [15:0] r_sum;
    logic [7:0]  r_words_left;
    logic        r_open;

    // Output word register
    logic        r_out_valid;
    t_frame_item r_out;

    // Per-word logic
    logic        is_header;
    logic        stray;
    logic [7:0]  sat_cnt;
    logic [15:0] len_word;
    logic [15:0] hdr_sum;
    logic [15:0] pay_sum;
    logic [7:0]  wl_next;
    t_slot       last_slot;
    logic [15:0] n_word;
    logic        n_end;
    logic        can_emit;
    logic        emit;
    logic        done;
    logic        in_ready;

    always_comb begin
        is_header = (r_cmd.command == CMD_HEADER);
        stray     = !is_header && !r_open;

        // Clamp the length and build the header part of the checksum
        sat_cnt   = (r_cmd.word_count > MAX_COUNT) ? MAX_COUNT : r_cmd.word_count;
        len_word  = {8'd0, sat_cnt} + HEAD_WORDS;
        hdr_sum   = len_word + r_cmd.cmd_id + r_cmd.channel + r_cmd.sub_number;

        pay_sum   = r_sum + r_cmd.payload_word;
        wl_next   = (r_words_left != 8'd0) ? (r_words_left - 8'd1) : 8'd0;

        if (is_header) begin
            last_slot = (sat_cnt == 8'd0) ? SLOT_HDR_SUM : SLOT_NO;
        end else begin
            last_slot = (wl_next == 8'd0) ? SLOT_PAY_SUM : SLOT_PAY_WORD;
        end

        n_end = 1'b0;
        if (is_header) begin
            case (r_idx)
                SLOT_SYNC: n_word = SYNC_WORD;
                SLOT_LEN:  n_word = len_word;
                SLOT_ID:   n_word = r_cmd.cmd_id;
                SLOT_CH:   n_word = r_cmd.channel;
                SLOT_NO:   n_word = r_cmd.sub_number;
                SLOT_HDR_SUM: begin
                    n_word = hdr_sum;
                    n_end  = 1'b1;
                end
                default:   n_word = SYNC_WORD;
            endcase
        end else begin
            case (r_idx)
                SLOT_PAY_WORD: n_word = r_cmd.payload_word;
                SLOT_PAY_SUM: begin
                    n_word = pay_sum;
                    n_end  = 1'b1;
                end
                default:       n_word = r_cmd.payload_word;
            endcase
        end

        // Advance one word when the output register is free or being drained
        can_emit = !r_out_valid || o_frame.ready;
        emit     = r_in_valid && !stray && can_emit;
        done     = r_in_valid && (stray || (emit && (r_idx == last_slot)));
        in_ready = !r_in_valid || done;
    end

    assign i_cmd.ready     = in_ready;
    assign o_frame.valid   = r_out_valid;
    assign o_frame.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_idx        <= SLOT_SYNC;
            r_sum        <= 16'd0;
            r_words_left <= 8'd0;
            r_open       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Take the next beat once the held item is finished
            if (in_ready) begin
                r_in_valid <= i_cmd.valid;
            end

            if (done) begin
                r_idx <= SLOT_SYNC;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
            end

            if (can_emit) begin
                r_out_valid <= emit;
            end

            // Commit frame state at the end of the item; drop stray beats
            if (done && !stray) begin
                if (is_header) begin
                    if (sat_cnt == 8'd0) begin
                        r_sum        <= 16'd0;
                        r_words_left <= 8'd0;
                        r_open       <= 1'b0;
                    end else begin
                        r_sum        <= hdr_sum;
                        r_words_left <= sat_cnt;
                        r_open       <= 1'b1;
                    end
                end else begin
                    r_sum        <= (wl_next == 8'd0) ? 16'd0 : pay_sum;
                    r_words_left <= wl_next;
                    r_open       <= (wl_next != 8'd0);
                end
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (in_ready && i_cmd.valid) begin
            r_cmd <= i_cmd.payload;
        end
        if (emit) begin
            r_out.frame_word <= n_word;
            r_out.frame_end  <= n_end;
        end
    end

    // An open frame always expects at least one more payload word
    `CFB_ASSERT_SAME(a_open_has_words, i_clk, i_rst_n, r_open, r_words_left != 8'd0)
    // Word slot restarts after every finished item
    `CFB_ASSERT_NEXT(a_slot_restart, i_clk, i_rst_n, done, r_idx == SLOT_SYNC)
    // First word of a header is the sync word and never ends a frame
    `CFB_ASSERT_NEXT(a_sync_first, i_clk, i_rst_n, emit && is_header && (r_idx == SLOT_SYNC), o_frame.valid && (o_frame.payload.frame_word == SYNC_WORD) && !o_frame.payload.frame_end)
    // Slot index never runs past the checksum slot
    `CFB_ASSERT_SAME(a_slot_range, i_clk, i_rst_n, r_in_valid, r_idx <= SLOT_HDR_SUM)

endmodule
